FILE: hdl/assert_macros.svh
// Assertion helpers shared by the deframer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/tsd_pkg.sv
package tsd_pkg;

	// header layout
	localparam logic [8:0] HDR_LAST   = 9'd511;
	localparam logic [8:0] NAME_BYTES = 9'd100;
	localparam logic [8:0] SIZE_OFF   = 9'd124;
	localparam logic [8:0] SIZE_END   = 9'd136;
	localparam logic [8:0] TYPE_OFF   = 9'd156;
	localparam logic [32:0] END_MARGIN = 33'd1024;

	// characters of interest
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_FIVE  = 8'h35;
	localparam logic [7:0] CH_SEVEN = 8'h37;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_PAD     = 2'd2,
		PH_DONE    = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HDR  = 2'd0,
		KIND_FILE = 2'd1,
		KIND_SKIP = 2'd2,
		KIND_OFF  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_RUN       = 3'd0,
		ST_END       = 3'd1,
		ST_BAD_NAME  = 3'd2,
		ST_BAD_DIGIT = 3'd3,
		ST_BAD_TYPE  = 3'd4,
		ST_TRUNC     = 3'd5
	} status_t;

	// running name check
	typedef struct packed {
		logic       ended;
		logic       bad;
		logic [1:0] cnt;   // segment length, saturates at 3
		logic       dots;  // segment so far is all dots
		logic       any;   // name has a non-slash char
	} name_chk_t;

	localparam name_chk_t NAME_RESET = '{ended: 1'b0, bad: 1'b0, cnt: 2'd0,
		dots: 1'b1, any: 1'b0};

	typedef struct packed {
		logic started;
		logic stopped;
		logic bad;
	} size_flags_t;

	// one result item
	typedef struct packed {
		status_t     status;
		logic [35:0] entry_size;
		logic        entry_is_dir;
		logic        header_done;
		kind_t       byte_kind;
		logic [7:0]  out_byte;
	} result_t;

	function automatic logic seg_is_dots(input name_chk_t nc);
		seg_is_dots = (nc.cnt == 2'd1 || nc.cnt == 2'd2) && nc.dots;
	endfunction

	function automatic name_chk_t name_finish(input name_chk_t nc);
		name_chk_t r;
		r = nc;
		if (!nc.ended) begin
			if (!nc.any || seg_is_dots(nc))
				r.bad = 1'b1;
			r.ended = 1'b1;
		end
		name_finish = r;
	endfunction

	function automatic name_chk_t name_feed(input name_chk_t nc, input logic first,
			input logic [7:0] b);
		name_chk_t r;
		r = nc;
		if (nc.ended) begin
			r = nc;
		end else if (b == CH_NUL) begin
			r = name_finish(nc);
		end else if (b == CH_SLASH) begin
			if (first || nc.cnt == 2'd0 || seg_is_dots(nc))
				r.bad = 1'b1;
			r.cnt = 2'd0;
			r.dots = 1'b1;
		end else begin
			r.any = 1'b1;
			if (nc.cnt != 2'd3)
				r.cnt = nc.cnt + 2'd1;
			if (b != CH_DOT)
				r.dots = 1'b0;
		end
		name_feed = r;
	endfunction

endpackage

FILE: hdl/tsd_core.sv
`include "assert_macros.svh"

module tsd_core
	import tsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,            // one byte transfer this cycle
	input  logic [7:0]  data_byte,
	input  logic [31:0] archive_length,
	output result_t     res              // result for the byte at data_byte
);

	logic [31:0] offset_q, offset_d;
	phase_t      phase_q, phase_d;
	logic [8:0]  hidx_q, hidx_d;
	logic        blank_q, blank_d;
	name_chk_t   name_q, name_d;
	logic [35:0] size_q, size_d;
	size_flags_t sflags_q, sflags_d;
	logic [7:0]  type_q, type_d;
	logic [35:0] payload_q, payload_d;
	logic [8:0]  pad_q, pad_d;
	status_t     status_q, status_d;

	logic        end_hit, run, hdr_last, zero_hdr, trunc;
	name_chk_t   nc_fin;
	logic [7:0]  type_eff;
	status_t     fin_status;
	logic [8:0]  pad_new;
	logic [35:0] payload_dec;
	logic [8:0]  pad_dec;

	// archive end check at a header start
	assign end_hit = (status_q == ST_RUN) && (phase_q == PH_HEADER) && (hidx_q == 9'd0) &&
		(({1'b0, offset_q} + END_MARGIN) > {1'b0, archive_length});
	assign run = (status_q == ST_RUN) && !end_hit;

	// evaluation on the last header byte
	assign hdr_last = (hidx_q == HDR_LAST);
	assign nc_fin   = name_finish(name_q);
	assign type_eff = (type_q == CH_NUL) ? CH_ZERO : type_q;
	assign zero_hdr = blank_q && (data_byte == CH_NUL);
	assign trunc    = ({5'd0, offset_q} + 37'd1 + {1'b0, size_q}) >
		{5'd0, archive_length};
	assign pad_new  = 9'(~size_q[8:0] + 9'd1);
	assign payload_dec = payload_q - 36'd1;
	assign pad_dec     = pad_q - 9'd1;

	always_comb begin
		if (zero_hdr)
			fin_status = ST_END;
		else if (nc_fin.bad)
			fin_status = ST_BAD_NAME;
		else if (sflags_q.bad)
			fin_status = ST_BAD_DIGIT;
		else if (type_eff != CH_FIVE && type_eff != CH_ZERO)
			fin_status = ST_BAD_TYPE;
		else if (type_eff == CH_ZERO && trunc)
			fin_status = ST_TRUNC;
		else
			fin_status = ST_RUN;
	end

	// next state
	always_comb begin
		offset_d   = (offset_q == 32'hffff_ffff) ? offset_q : offset_q + 32'd1;
		phase_d    = phase_q;
		hidx_d     = hidx_q;
		blank_d    = blank_q;
		name_d     = name_q;
		size_d     = size_q;
		sflags_d   = sflags_q;
		type_d     = type_q;
		payload_d  = payload_q;
		pad_d      = pad_q;
		status_d   = status_q;
		if (end_hit) begin
			status_d = ST_END;
			phase_d  = PH_DONE;
		end else if (run) begin
			case (phase_q)
				PH_HEADER: begin
					if (data_byte != CH_NUL)
						blank_d = 1'b0;
					if (hidx_q < NAME_BYTES)
						name_d = name_feed(name_q, hidx_q == 9'd0, data_byte);
					// octal size field
					if (hidx_q >= SIZE_OFF && hidx_q < SIZE_END &&
							!sflags_q.stopped && !sflags_q.bad) begin
						if (!sflags_q.started && (data_byte == CH_SPACE ||
								data_byte == CH_NUL)) begin
							sflags_d = sflags_q;
						end else begin
							sflags_d.started = 1'b1;
							if (data_byte == CH_SPACE || data_byte == CH_NUL)
								sflags_d.stopped = 1'b1;
							else if (data_byte < CH_ZERO || data_byte > CH_SEVEN)
								sflags_d.bad = 1'b1;
							else
								size_d = {size_q[32:0], 3'(data_byte - CH_ZERO)};
						end
					end
					if (hidx_q == TYPE_OFF)
						type_d = data_byte;
					if (hdr_last) begin
						type_d   = type_eff;
						status_d = fin_status;
						if (fin_status != ST_RUN) begin
							phase_d = PH_DONE;
						end else begin
							payload_d = size_q;
							pad_d     = pad_new;
							if (size_q != 36'd0)
								phase_d = PH_PAYLOAD;
							else if (pad_new != 9'd0)
								phase_d = PH_PAD;
							else
								phase_d = PH_HEADER;
						end
						hidx_d     = 9'd0;
						blank_d    = 1'b1;
						name_d     = NAME_RESET;
						size_d     = 36'd0;
						sflags_d   = '0;
					end else begin
						hidx_d = hidx_q + 9'd1;
					end
				end
				PH_PAYLOAD: begin
					payload_d = payload_dec;
					if (payload_dec == 36'd0)
						phase_d = (pad_q != 9'd0) ? PH_PAD : PH_HEADER;
				end
				PH_PAD: begin
					pad_d = pad_dec;
					if (pad_dec == 9'd0)
						phase_d = PH_HEADER;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// result fields
	always_comb begin
		res.out_byte     = data_byte;
		res.byte_kind    = KIND_OFF;
		res.header_done  = 1'b0;
		res.entry_is_dir = 1'b0;
		res.entry_size   = 36'd0;
		res.status       = status_d;
		if (run) begin
			case (phase_q)
				PH_HEADER: begin
					res.byte_kind = KIND_HDR;
					if (hdr_last && fin_status == ST_RUN) begin
						res.header_done  = 1'b1;
						res.entry_is_dir = (type_eff == CH_FIVE);
						res.entry_size   = size_q;
					end
				end
				PH_PAYLOAD: res.byte_kind = (type_q == CH_FIVE) ? KIND_SKIP : KIND_FILE;
				PH_PAD:     res.byte_kind = KIND_SKIP;
				default:    res.byte_kind = KIND_OFF;
			endcase
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= 32'd0;
			phase_q    <= PH_HEADER;
			hidx_q     <= 9'd0;
			blank_q    <= 1'b1;
			name_q     <= NAME_RESET;
			size_q     <= 36'd0;
			sflags_q   <= '0;
			type_q     <= 8'd0;
			payload_q  <= 36'd0;
			pad_q      <= 9'd0;
			status_q   <= ST_RUN;
		end else if (step) begin
			offset_q   <= offset_d;
			phase_q    <= phase_d;
			hidx_q     <= hidx_d;
			blank_q    <= blank_d;
			name_q     <= name_d;
			size_q     <= size_d;
			sflags_q   <= sflags_d;
			type_q     <= type_d;
			payload_q  <= payload_d;
			pad_q      <= pad_d;
			status_q   <= status_d;
		end
	end

	`ASSERT_IMPL(a_done_iff_stopped, clk, arst_n, 1'b1, (phase_q == PH_DONE) == (status_q != ST_RUN))
	`ASSERT_NEXT(a_status_sticky, clk, arst_n, status_q != ST_RUN, $stable(status_q))
	`ASSERT_IMPL(a_payload_nonzero, clk, arst_n, phase_q == PH_PAYLOAD, payload_q != 36'd0)

endmodule

FILE: hdl/tar_stream_deframer_unit.sv
// Output: a byte accepted on s_axis is registered and appears on m_axis in the next cycle.
// Throughput: one byte per cycle while m_axis_tready is high; the single output register
// frees in the same cycle it is taken, so input and output run back to back.
// Reset: arst_n clears the parse state, the status and archive_length to zero
// and empties the output register.
`include "assert_macros.svh"

module tar_stream_deframer_unit
	import tsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// archive_length write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	// input bytes
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	// classified bytes
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // [7:0] out_byte, [8] header_done,
	                                    // [9] entry_is_dir, [45:10] entry_size,
	                                    // [48:46] status, [55:49] zero
	output logic [1:0]  m_axis_tuser    // [1:0] byte_kind
);

	logic [31:0] alen_q;
	logic        out_valid_q;
	result_t     out_q;
	result_t     res;
	logic        step;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			alen_q <= 32'd0;
		else if (cfg_valid && cfg_ready)
			alen_q <= cfg_data;
	end

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign step = s_axis_tvalid && s_axis_tready;

	tsd_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.data_byte      (s_axis_tdata),
		.archive_length (alen_q),
		.res            (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step)
			out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_q.status, out_q.entry_size, out_q.entry_is_dir,
		out_q.header_done, out_q.out_byte};
	assign m_axis_tuser  = out_q.byte_kind;

	`ASSERT_IMPL(a_stall_means_full, clk, arst_n, !s_axis_tready, m_axis_tvalid)
	`ASSERT_IMPL(a_hdone_only_running, clk, arst_n, m_axis_tvalid && out_q.header_done, (out_q.status == ST_RUN) && (out_q.byte_kind == KIND_HDR))
	`ASSERT_IMPL(a_running_not_off, clk, arst_n, m_axis_tvalid && out_q.status == ST_RUN, out_q.byte_kind != KIND_OFF)

endmodule
